/* rtl/core/ympf_pkg.sv */
package ympf_pkg;

   // Framing bytes, CRC generator and payload sizes.
   localparam logic [7:0]  BYTE_SOH      = 8'h01;
   localparam logic [7:0]  BYTE_STX      = 8'h02;
   localparam logic [7:0]  BYTE_PAD      = 8'h1A;
   localparam logic [7:0]  BYTE_ZERO     = 8'h00;
   localparam logic [15:0] CRC_GENERATOR = 16'h1021;
   localparam logic [10:0] SMALL_PAYLOAD = 11'd128;
   localparam logic [10:0] LARGE_PAYLOAD = 11'd1024;

   // Request action codes.
   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_DATA  = 1'b1;

   // Result queue geometry: one request can push up to three results.
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PER_REQ = 3;

   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] data;
      logic [2:0]      last;
   } push_type;

   // One byte of CRC-16/XMODEM, MSB first, no reflection, no final xor.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_GENERATOR;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* rtl/core/ympf_req_if.sv */
interface ympf_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [7:0]  packet_number;
   logic [10:0] block_length;
   logic        pad_zero;
   logic [7:0]  data_byte;

   modport source (output valid, action, packet_number, block_length, pad_zero, data_byte,
                   input ready);
   modport sink   (input valid, action, packet_number, block_length, pad_zero, data_byte,
                   output ready);
endinterface

/* rtl/core/ympf_rsp_if.sv */
interface ympf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       packet_end;

   modport source (output valid, out_byte, packet_end, input ready);
   modport sink   (input valid, out_byte, packet_end, output ready);
endinterface

/* rtl/core/ympf_framer.sv */
module ympf_framer (
   input  logic              clock,
   input  logic              reset,
   ympf_req_if.sink          req,
   input  logic              push_ok,
   output ympf_pkg::push_type push
);

   logic        stage_valid_ff, stage_valid_in;
   logic        action_ff;
   logic [7:0]  number_ff;
   logic [10:0] length_ff;
   logic        pad_zero_ff;
   logic [7:0]  data_ff;

   logic        in_packet_ff, in_packet_in;
   logic        large_ff, large_in;
   logic [10:0] position_ff, position_in;
   logic [10:0] count_ff, count_in;
   logic        pad_is_zero_ff, pad_is_zero_in;
   logic [15:0] crc_ff, crc_in;

   logic        accept;
   logic        move;
   logic [10:0] sat_length;
   logic        start_large;
   logic [7:0]  payload;
   logic [15:0] crc_next;
   logic [10:0] position_next;
   logic [10:0] size;
   logic        done;

   assign req.ready = !stage_valid_ff || push_ok;
   assign accept    = req.valid && req.ready;
   assign move      = stage_valid_ff && push_ok;

   assign stage_valid_in = accept || (stage_valid_ff && !move);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff   <= req.action;
         number_ff   <= req.packet_number;
         length_ff   <= req.block_length;
         pad_zero_ff <= req.pad_zero;
         data_ff     <= req.data_byte;
      end
   end

   assign sat_length    = (length_ff > ympf_pkg::LARGE_PAYLOAD) ? ympf_pkg::LARGE_PAYLOAD
                                                                 : length_ff;
   assign start_large   = sat_length > ympf_pkg::SMALL_PAYLOAD;
   assign payload       = (position_ff < count_ff) ? data_ff
                        : (pad_is_zero_ff ? ympf_pkg::BYTE_ZERO : ympf_pkg::BYTE_PAD);
   assign crc_next      = ympf_pkg::crc_feed(crc_ff, payload);
   assign position_next = position_ff + 11'd1;
   assign size          = large_ff ? ympf_pkg::LARGE_PAYLOAD : ympf_pkg::SMALL_PAYLOAD;
   assign done          = position_next >= size;

   always_comb begin
      in_packet_in   = in_packet_ff;
      large_in       = large_ff;
      position_in    = position_ff;
      count_in       = count_ff;
      pad_is_zero_in = pad_is_zero_ff;
      crc_in         = crc_ff;
      push.count     = 2'd0;
      push.data      = '0;
      push.last      = '0;
      if (move) begin
         if (action_ff == ympf_pkg::ACTION_START) begin
            in_packet_in   = 1'b1;
            large_in       = start_large;
            position_in    = '0;
            count_in       = sat_length;
            pad_is_zero_in = pad_zero_ff;
            crc_in         = '0;
            push.count     = 2'd3;
            push.data[0]   = start_large ? ympf_pkg::BYTE_STX : ympf_pkg::BYTE_SOH;
            push.data[1]   = number_ff;
            push.data[2]   = ~number_ff;
         end else if (in_packet_ff) begin
            crc_in       = crc_next;
            position_in  = position_next;
            push.data[0] = payload;
            if (done) begin
               in_packet_in = 1'b0;
               push.count   = 2'd3;
               push.data[1] = crc_next[15:8];
               push.data[2] = crc_next[7:0];
               push.last[2] = 1'b1;
            end else begin
               push.count = 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff   <= 1'b0;
         large_ff       <= 1'b0;
         position_ff    <= '0;
         count_ff       <= '0;
         pad_is_zero_ff <= 1'b0;
         crc_ff         <= '0;
      end else begin
         in_packet_ff   <= in_packet_in;
         large_ff       <= large_in;
         position_ff    <= position_in;
         count_ff       <= count_in;
         pad_is_zero_ff <= pad_is_zero_in;
         crc_ff         <= crc_in;
      end
   end

endmodule

/* rtl/core/ympf_rsp_fifo.sv */
module ympf_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  ympf_pkg::push_type push,
   output logic              push_ok,
   ympf_rsp_if.source        rsp
);

   localparam int PtrWidth = $clog2(ympf_pkg::RSP_DEPTH);
   localparam int CntWidth = $clog2(ympf_pkg::RSP_DEPTH + 1);

   logic [7:0]          data_mem [ympf_pkg::RSP_DEPTH];
   logic                last_mem [ympf_pkg::RSP_DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                pop;

   // Room for a full three-result request, regardless of this cycle's pop.
   assign push_ok = count_ff <= CntWidth'(ympf_pkg::RSP_DEPTH - ympf_pkg::RSP_PER_REQ);

   assign rsp.valid      = count_ff != '0;
   assign rsp.out_byte   = data_mem[rd_ptr_ff];
   assign rsp.packet_end = last_mem[rd_ptr_ff];
   assign pop            = rsp.valid && rsp.ready;

   assign wr_ptr_in = wr_ptr_ff + PtrWidth'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PtrWidth'(pop);
   assign count_in  = count_ff + CntWidth'(push.count) - CntWidth'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < ympf_pkg::RSP_PER_REQ; i++) begin
         if (i < int'(push.count)) begin
            data_mem[wr_ptr_ff + PtrWidth'(i)] <= push.data[i];
            last_mem[wr_ptr_ff + PtrWidth'(i)] <= push.last[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/ymodem_packet_framer_core.sv */
// Path: a request is first held in the framer's stage register; once the response queue
// has room for three bytes, its bytes are written into the queue and are valid at its output.
// Throughput: one request per cycle while each yields one byte and the consumer takes every
// byte; a start request or a packet's last payload request yields three bytes, and the
// one-byte-per-cycle response port paces requests to match.
// Reset: synchronous, active high; clears the packet state, the CRC and the response queue.
module ymodem_packet_framer_core (
   input  logic        clock,
   input  logic        reset,
   ympf_req_if.sink    req,
   ympf_rsp_if.source  rsp
);

   // The framer holds one registered request and the packet state. When the response
   // queue has room for three bytes, the held request is processed in a single pass:
   // header bytes for a start request, or a payload byte (data or pad) with a CRC
   // update, plus the two CRC bytes when the payload is complete.
   ympf_pkg::push_type push;
   logic               push_ok;

   ympf_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .push_ok (push_ok),
      .push    (push)
   );

   // The response queue parts the two sides, so a new request can be taken while earlier
   // bytes still wait for the consumer, as long as the queue has room for three more bytes.
   ympf_rsp_fifo u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_ok (push_ok),
      .rsp     (rsp)
   );

endmodule
